FILE: hdl/mih_pkg.sv
// ----------------------------------------------------------------------------
// mih_pkg
// Shared types and constants of the masked intensity histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mih_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int COUNT_BITS  = 40;
  localparam int BIN_COUNT   = 1 << SAMPLE_BITS;

  localparam int FUNC_BITS   = 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 1;

  // Input word: red_or_gray, green, blue, mask_level, bin_select.
  localparam int IN_RAW_BITS   = 5 * SAMPLE_BITS;
  localparam int IN_TDATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
  // Output word: bin_number, bin_total.
  localparam int OUT_RAW_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ACCUM = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COLOR_MODE = 1'b0,
    REG_USE_MASK   = 1'b1
  } cfg_reg_e;

endpackage

FILE: hdl/mih_ram.sv
// ----------------------------------------------------------------------------
// mih_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/masked_intensity_histogram.sv
// ----------------------------------------------------------------------------
// masked_intensity_histogram
// Weighted value histogram of a pixel stream with bin read and bin clear.
// ----------------------------------------------------------------------------
// Read path: an accepted read word enters stage 1 together with its bin's RAM
// read data, and the result word is registered from stage 1 into the output.
// Throughput: one word per cycle; the bin RAM read-modify-write loop forwards
// back-to-back hits. Input stalls only while a read waits on a full output.
// Reset: every bin reads as zero through per-bin valid flops, no clear pass.
`timescale 1ns / 1ps

module masked_intensity_histogram
  import mih_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // red_or_gray, green, blue, mask_level, bin_select
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // func
  input  logic [FUNC_BITS-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // bin_number, bin_total
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  localparam int IDX_BITS = SAMPLE_BITS;

  logic color_mode_q, use_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      use_mask_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COLOR_MODE: color_mode_q <= cfg_data_i[0];
        REG_USE_MASK:   use_mask_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic [SAMPLE_BITS-1:0] red_gray, green, blue, mask_level, bin_select;
  assign red_gray   = s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign green      = s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign blue       = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign mask_level = s_axis_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
  assign bin_select = s_axis_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];

  logic                   in_acc, in_rd, in_clr;
  logic [SAMPLE_BITS-1:0] rgb_max, pix_idx;
  logic [IDX_BITS-1:0]    in_idx;
  logic [SAMPLE_BITS-1:0] in_weight;

  always_comb begin
    in_acc = 1'b0;
    in_rd  = 1'b0;
    in_clr = 1'b0;
    unique case (s_axis_tuser)
      FUNC_ACCUM: in_acc = 1'b1;
      FUNC_READ:  in_rd  = 1'b1;
      FUNC_CLEAR: in_clr = 1'b1;
      default: ;
    endcase
    rgb_max = (green > red_gray) ? green : red_gray;
    rgb_max = (blue > rgb_max) ? blue : rgb_max;
    pix_idx   = color_mode_q ? rgb_max : red_gray;
    in_idx    = in_acc ? pix_idx : bin_select;
    in_weight = use_mask_q ? mask_level : FULL_SCALE;
  end

  // Stage 1: bin data arrives from the RAM.
  logic                   s1_valid_q, s1_acc_q, s1_rd_q;
  logic [IDX_BITS-1:0]    s1_idx_q;
  logic [SAMPLE_BITS-1:0] s1_weight_q;

  // Write made in the same cycle as the stage 1 word's RAM read.
  logic                   fwd_en_q;
  logic [IDX_BITS-1:0]    fwd_idx_q;
  logic [COUNT_BITS-1:0]  fwd_data_q;

  logic [BIN_COUNT-1:0]   bin_valid_q;
  logic                   out_valid_q;
  logic [IDX_BITS-1:0]    out_num_q;
  logic [COUNT_BITS-1:0]  out_total_q;

  logic                   stall, accept;
  logic                   ram_we;
  logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata, cur_total;
  logic [COUNT_BITS:0]    sum;
  logic [COUNT_BITS-1:0]  sat_total;

  assign stall         = s1_valid_q && s1_rd_q && out_valid_q && !m_axis_tready;
  assign s_axis_tready = !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (fwd_en_q && (fwd_idx_q == s1_idx_q)) begin
      cur_total = fwd_data_q;
    end else if (bin_valid_q[s1_idx_q]) begin
      cur_total = ram_rdata;
    end else begin
      cur_total = '0;
    end
    sum       = {1'b0, cur_total} + (COUNT_BITS + 1)'(s1_weight_q);
    sat_total = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    ram_we    = s1_valid_q && !s1_rd_q;
    ram_wdata = s1_acc_q ? sat_total : '0;
  end

  mih_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_acc_q    <= 1'b0;
      s1_rd_q     <= 1'b0;
      fwd_en_q    <= 1'b0;
      bin_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid_q <= accept && (in_acc || in_rd || in_clr);
        s1_acc_q   <= in_acc;
        s1_rd_q    <= in_rd;
      end
      if (accept) begin
        fwd_en_q <= ram_we;
      end
      if (ram_we) begin
        bin_valid_q[s1_idx_q] <= 1'b1;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_rd_q && !stall) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_idx_q    <= in_idx;
      s1_weight_q <= in_weight;
    end
    if (accept) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= ram_wdata;
    end
    if (s1_valid_q && s1_rd_q && !stall) begin
      out_num_q   <= s1_idx_q;
      out_total_q <= cur_total;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'({out_total_q, out_num_q});

endmodule

FILE: hdl/mih_checker.sv
// ----------------------------------------------------------------------------
// mih_checker
// Port-level checks of the masked intensity histogram, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mih_checker
  import mih_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  input logic [FUNC_BITS-1:0]      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic rd_accept;
  assign rd_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_READ);

  // A result word stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before it was taken");

  // A read accepted into an empty output gives a result word through stage 1 and the output register.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_accept && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("read word produced no result");

  // A new result only follows an accepted read.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rd_accept, 2))
    else $error("result word without a read");

  // The result names the bin that the read selected.
  a_bin_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      m_axis_tdata[SAMPLE_BITS-1:0] ==
        $past(s_axis_tdata[4*SAMPLE_BITS +: SAMPLE_BITS], 2))
    else $error("result bin number differs from the selected bin");

endmodule

bind masked_intensity_histogram mih_checker u_mih_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
